// ===== rtl/mbrc_pkg.sv =====
// Shared types, constants and the CRC-16 byte fold for the Modbus RTU read request checker.
package mbrc_pkg;

   localparam int MAX_FRAME_DEFAULT = 64;

   localparam int BYTE_W   = 8;
   localparam int CMD_W    = 2;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int PLEN_W   = 6;
   localparam int CRC_W    = 16;

   // req_tdata: slave_id, start_address, register_count, rx_byte (48 bits)
   localparam int REQ_DATA_W = 48;
   // rsp_tdata: data_byte, status, payload_length (16 bits)
   localparam int RSP_DATA_W = 16;

   localparam logic [BYTE_W-1:0] FUNC_READ_HOLDING = 8'h03;
   localparam logic [CRC_W-1:0]  CRC_POLY          = 16'hA001;
   localparam logic [CRC_W-1:0]  CRC_INIT          = 16'hFFFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_REQUEST   = 2'd0,
      CMD_RX_BYTE   = 2'd1,
      CMD_END_FRAME = 2'd2
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_TX      = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_STATUS  = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_CRC_ERR  = 2'd1,
      ST_NO_REPLY = 2'd2,
      ST_SHORT    = 2'd3
   } status_type;

   // transmit beat offered by the request serializer
   typedef struct packed {
      logic              busy;
      logic [BYTE_W-1:0] data;
      logic              last;
   } tx_beat_type;

   // reflected CRC-16, one byte, LSB first
   function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/mbrc_tx_seq.sv =====
// Request serializer: walks the remaining seven request bytes and builds the CRC as it goes.
module mbrc_tx_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mbrc_pkg::BYTE_W-1:0]   slave_id,
   input  logic [15:0]                   start_address,
   input  logic [15:0]                   register_count,
   input  logic                          advance,
   output mbrc_pkg::tx_beat_type         tx
);
   import mbrc_pkg::*;

   logic                  busy_ff, busy_in;
   logic [2:0]            idx_ff, idx_in;
   logic [CRC_W-1:0]      crc_ff, crc_in;
   logic [5*BYTE_W-1:0]   shift_ff, shift_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      crc_ff   <= crc_in;
      shift_ff <= shift_in;
   end

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      crc_in   = crc_ff;
      shift_in = shift_ff;
      tx.busy  = busy_ff;
      tx.last  = 1'b0;
      tx.data  = shift_ff[BYTE_W-1:0];
      if (idx_ff == 3'd6) begin
         tx.data = crc_ff[7:0];
      end else if (idx_ff == 3'd7) begin
         tx.data = crc_ff[15:8];
         tx.last = 1'b1;
      end

      if (start) begin
         // slave id goes to the result register on the accept cycle; the rest queues here
         busy_in  = 1'b1;
         idx_in   = 3'd1;
         crc_in   = crc_fold(CRC_INIT, slave_id);
         shift_in = {register_count[7:0], register_count[15:8],
                     start_address[7:0], start_address[15:8], FUNC_READ_HOLDING};
      end else if (busy_ff && advance) begin
         idx_in = idx_ff + 3'd1;
         if (idx_ff < 3'd6) begin
            crc_in   = crc_fold(crc_ff, shift_ff[BYTE_W-1:0]);
            shift_in = shift_ff >> BYTE_W;
         end
         if (idx_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
   end

endmodule

// ===== rtl/modbus_rtu_read_request_checker_core.sv =====
// Modbus RTU read-holding-registers client core: request framing and response CRC check.
// Output is registered: a result made by an accepted beat appears on rsp in the cycle after it.
// Throughput: receive and end-of-frame beats at one per cycle while rsp is not stalled; a
//   request sends eight transmit bytes, and no new beat is taken until the last is issued.
// req_tready is low while a request is being serialized or a result is stalled.
// Reset (synchronous) clears the receive CRC to 0xFFFF, count and delay line to zero.
module modbus_rtu_read_request_checker_core #(
   parameter int MaxFrame = mbrc_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] slave_id, [23:8] start_address, [39:24] register_count, [47:40] rx_byte
   input  logic [mbrc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] cmd
   input  logic [mbrc_pkg::CMD_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] data_byte, [9:8] status, [15:10] payload_length
   output logic [mbrc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [1:0] kind
   output logic [mbrc_pkg::KIND_W-1:0]        rsp_tuser,
   output logic                               rsp_tlast
);
   import mbrc_pkg::*;

   localparam int CountW = $clog2(MaxFrame + 1);
   localparam int ExtW   = CountW + PLEN_W;

   logic [BYTE_W-1:0] slave_id, rx_byte;
   logic [15:0]       start_address, register_count;
   cmd_type           cmd;

   assign slave_id       = req_tdata[7:0];
   assign start_address  = req_tdata[23:8];
   assign register_count = req_tdata[39:24];
   assign rx_byte        = req_tdata[47:40];
   assign cmd            = cmd_type'(req_tuser);

   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [PLEN_W-1:0] rsp_plen_ff, rsp_plen_in;

   logic [CRC_W-1:0]  rx_crc_ff, rx_crc_in;
   logic [CountW-1:0] rx_count_ff, rx_count_in;
   logic [BYTE_W-1:0] held_older_ff, held_older_in;
   logic [BYTE_W-1:0] held_newer_ff, held_newer_in;

   logic              out_free, accept, tx_start;
   logic [ExtW-1:0]   count_ext;
   tx_beat_type       tx;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = out_free && !tx.busy;
   assign accept     = req_tvalid && req_tready;
   assign tx_start   = accept && (cmd == CMD_REQUEST);
   assign count_ext  = ExtW'(rx_count_ff) - ExtW'(2);

   mbrc_tx_seq u_tx_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (tx_start),
      .slave_id       (slave_id),
      .start_address  (start_address),
      .register_count (register_count),
      .advance        (out_free),
      .tx             (tx)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         rx_crc_ff     <= CRC_INIT;
         rx_count_ff   <= '0;
         held_older_ff <= '0;
         held_newer_ff <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         rx_crc_ff     <= rx_crc_in;
         rx_count_ff   <= rx_count_in;
         held_older_ff <= held_older_in;
         held_newer_ff <= held_newer_in;
      end
      rsp_kind_ff   <= rsp_kind_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_plen_ff   <= rsp_plen_in;
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_plen_in   = rsp_plen_ff;
      rx_crc_in     = rx_crc_ff;
      rx_count_in   = rx_count_ff;
      held_older_in = held_older_ff;
      held_newer_in = held_newer_ff;

      if (out_free) begin
         rsp_valid_in  = 1'b0;
         rsp_kind_in   = KIND_TX;
         rsp_data_in   = '0;
         rsp_last_in   = 1'b0;
         rsp_status_in = ST_OK;
         rsp_plen_in   = '0;
         if (tx.busy) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = tx.data;
            rsp_last_in  = tx.last;
         end else if (req_tvalid) begin
            unique case (cmd)
               CMD_REQUEST: begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = slave_id;
                  rx_crc_in     = CRC_INIT;
                  rx_count_in   = '0;
                  held_older_in = '0;
                  held_newer_in = '0;
               end
               CMD_RX_BYTE: begin
                  // saturated frame: extra bytes are dropped
                  if (rx_count_ff != CountW'(MaxFrame)) begin
                     rx_count_in = rx_count_ff + CountW'(1);
                     if (rx_count_ff >= CountW'(2)) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_PAYLOAD;
                        rsp_data_in  = held_older_ff;
                        rx_crc_in    = crc_fold(rx_crc_ff, held_older_ff);
                     end
                     held_older_in = held_newer_ff;
                     held_newer_in = rx_byte;
                  end
               end
               CMD_END_FRAME: begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_STATUS;
                  if (rx_count_ff == '0) begin
                     rsp_status_in = ST_NO_REPLY;
                  end else if (rx_count_ff < CountW'(3)) begin
                     rsp_status_in = ST_SHORT;
                  end else if (rx_crc_ff[7:0] == held_older_ff &&
                               rx_crc_ff[15:8] == held_newer_ff) begin
                     rsp_status_in = ST_OK;
                     rsp_plen_in   = count_ext[PLEN_W-1:0];
                  end else begin
                     rsp_status_in = ST_CRC_ERR;
                  end
                  rx_crc_in     = CRC_INIT;
                  rx_count_in   = '0;
                  held_older_in = '0;
                  held_newer_in = '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_plen_ff, rsp_status_ff, rsp_data_ff};

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      tx.busy |-> !req_tready)
      else $error("request accepted while serializer busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rx_count_ff <= CountW'(MaxFrame))
      else $error("receive count beyond frame limit");

   a_req_starts_seq: assert property (@(posedge clock) disable iff (reset)
      tx_start |=> tx.busy && rsp_tvalid && rsp_tuser == KIND_TX)
      else $error("request did not start transmit run");

   a_last_only_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_TX && !tx.busy)
      else $error("tlast outside end of transmit run");

   a_plen_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15:10] != '0 |->
         rsp_tuser == KIND_STATUS && rsp_tdata[9:8] == ST_OK)
      else $error("payload length on non-ok result");

endmodule
